// ===== rtl/dqs_pkg.sv =====
// Shared constants, codes and types for the double-ended queue with search.
package dqs_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DEPTH);

  localparam int IN_W  = FUNC_W + DATA_W;
  localparam int OUT_W = DATA_W + POS_W + STAT_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/double_ended_queue_with_search.sv =====
// Top level: bounded deque of signed 32-bit values held in a chain of cells.
//
// Requests enter on the s_ stream (func, value) and each yields exactly one
// result transaction on the m_ stream (removed_value, position, status).
// Entries sit in a row of DEPTH cells with the front in cell 0.
// Insert front and remove front shift the whole row by one place and finish
// in the accepting cycle; the result is visible on the next cycle.
// Insert back, remove back and search rotate the row left once per cycle
// through a full turn, comparing or replacing at cell 0, which brings the row
// back to its original order; the result is loaded after the rotation ends,
// once the output register is free.
// Full inserts, empty removals and unused codes answer at once, with no rotation.
// One request is in flight at a time; s_tready is high only when idle and
// the output register is free or being taken.
// Reset clears occupancy and handshake state; cell contents are left
// as they are and are never read before being written.
// If m_tready stays low, the result is held in the output register and no
// new request is accepted until it is taken.
module double_ended_queue_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] func, [34:3] value, [39:35] zero
  input  logic [dqs_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] removed_value, [38:32] position, [40:39] status, [47:41] zero
  output logic [dqs_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int DEPTH  = dqs_pkg::DEPTH;
  localparam int DATA_W = dqs_pkg::DATA_W;
  localparam int FUNC_W = dqs_pkg::FUNC_W;
  localparam int POS_W  = dqs_pkg::POS_W;
  localparam int STAT_W = dqs_pkg::STAT_W;
  localparam int OCC_W  = dqs_pkg::OCC_W;
  localparam int STEP_W = dqs_pkg::STEP_W;
  localparam int OUT_TDATA_W = dqs_pkg::OUT_TDATA_W;

  dqs_pkg::state_t   state, state_next;
  dqs_pkg::cell_op_t cell_op;

  logic [DATA_W-1:0] q [DEPTH];
  logic [DATA_W-1:0] head_in;
  logic [DATA_W-1:0] tail_in;

  logic [OCC_W-1:0]  occupancy, occupancy_next;
  logic [STEP_W-1:0] step;
  logic [FUNC_W-1:0] req_func;
  logic [DATA_W-1:0] req_value;
  logic              hit;
  logic [OCC_W-1:0]  found_pos;
  logic [DATA_W-1:0] walk_removed;

  logic [FUNC_W-1:0] in_func;
  logic [DATA_W-1:0] in_value;
  logic              accept;
  logic              out_free;
  logic              start_walk;
  logic              last_step;
  logic [OCC_W-1:0]  step_ext;
  logic              load_out;
  logic [DATA_W-1:0] res_removed;
  logic [POS_W-1:0]  res_pos;
  logic [STAT_W-1:0] res_status;

  assign in_func   = s_tdata[FUNC_W-1:0];
  assign in_value  = s_tdata[FUNC_W+DATA_W-1:FUNC_W];
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_step = (step == STEP_W'(DEPTH - 1));
  assign step_ext  = OCC_W'(step);

  // chain of cells: left neighbor feeds on a right shift, right neighbor on a left shift
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] from_left;
    logic [DATA_W-1:0] from_right;
    if (k == 0) begin : g_head
      assign from_left = head_in;
    end else begin : g_mid_l
      assign from_left = q[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign from_right = tail_in;
    end else begin : g_mid_r
      assign from_right = q[k+1];
    end
    dqs_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .from_left  (from_left),
      .from_right (from_right),
      .q          (q[k])
    );
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cell_op        = dqs_pkg::CELL_HOLD;
    head_in        = in_value;
    tail_in        = q[0];
    occupancy_next = occupancy;
    start_walk     = 1'b0;
    load_out       = 1'b0;
    res_removed    = '0;
    res_pos        = '0;
    res_status     = dqs_pkg::STAT_OK;
    unique case (state)
      dqs_pkg::ST_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          priority case (in_func)
            dqs_pkg::FN_INS_FRONT: begin
              load_out = 1'b1;
              if (occupancy == OCC_W'(DEPTH)) begin
                res_status = dqs_pkg::STAT_FULL;
              end else begin
                cell_op        = dqs_pkg::CELL_SHR;
                occupancy_next = occupancy + OCC_W'(1);
              end
            end
            dqs_pkg::FN_INS_BACK: begin
              if (occupancy == OCC_W'(DEPTH)) begin
                load_out   = 1'b1;
                res_status = dqs_pkg::STAT_FULL;
              end else begin
                start_walk = 1'b1;
              end
            end
            dqs_pkg::FN_REM_FRONT: begin
              load_out = 1'b1;
              if (occupancy == '0) begin
                res_status = dqs_pkg::STAT_EMPTY;
              end else begin
                res_removed    = q[0];
                cell_op        = dqs_pkg::CELL_SHL;
                occupancy_next = occupancy - OCC_W'(1);
              end
            end
            dqs_pkg::FN_REM_BACK: begin
              if (occupancy == '0) begin
                load_out   = 1'b1;
                res_status = dqs_pkg::STAT_EMPTY;
              end else begin
                start_walk = 1'b1;
              end
            end
            dqs_pkg::FN_SEARCH: begin
              start_walk = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
          if (start_walk) begin
            state_next = dqs_pkg::ST_WALK;
          end
        end
      end
      dqs_pkg::ST_WALK: begin
        // full left rotation; the back slot is passed through cell 0 at step == occupancy
        cell_op = dqs_pkg::CELL_SHL;
        if (req_func == dqs_pkg::FN_INS_BACK && step_ext == occupancy) begin
          tail_in = req_value;
        end
        if (last_step) begin
          state_next = dqs_pkg::ST_DONE;
          if (req_func == dqs_pkg::FN_INS_BACK) begin
            occupancy_next = occupancy + OCC_W'(1);
          end else if (req_func == dqs_pkg::FN_REM_BACK) begin
            occupancy_next = occupancy - OCC_W'(1);
          end
        end
      end
      dqs_pkg::ST_DONE: begin
        if (out_free) begin
          load_out    = 1'b1;
          state_next  = dqs_pkg::ST_IDLE;
          res_removed = walk_removed;
          if (req_func == dqs_pkg::FN_SEARCH) begin
            if (hit) begin
              res_pos = POS_W'(found_pos);
            end else begin
              res_pos    = POS_W'({1'b0, occupancy} + (OCC_W + 1)'(1));
              res_status = dqs_pkg::STAT_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_next = dqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqs_pkg::ST_IDLE;
      occupancy <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_TDATA_W'({res_status, res_pos, res_removed});
    end
    if (start_walk) begin
      req_func     <= in_func;
      req_value    <= in_value;
      step         <= '0;
      hit          <= 1'b0;
      found_pos    <= '0;
      walk_removed <= '0;
    end else if (state == dqs_pkg::ST_WALK) begin
      step <= step + STEP_W'(1);
      if (req_func == dqs_pkg::FN_REM_BACK && step_ext == occupancy - OCC_W'(1)) begin
        walk_removed <= q[0];
      end
      if (req_func == dqs_pkg::FN_SEARCH && !hit && step_ext < occupancy
          && q[0] == req_value) begin
        hit       <= 1'b1;
        found_pos <= step_ext + OCC_W'(1);
      end
    end
  end

  occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond capacity");

  ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == dqs_pkg::ST_IDLE)
    else $error("request taken outside idle");

  walk_advances: assert property (@(posedge clk) disable iff (rst)
    (state == dqs_pkg::ST_WALK && !last_step) |=>
      (state == dqs_pkg::ST_WALK && step == $past(step) + STEP_W'(1)))
    else $error("rotation step lost");

  walk_leaves_done: assert property (@(posedge clk) disable iff (rst)
    (state == dqs_pkg::ST_WALK && last_step) |=> state == dqs_pkg::ST_DONE)
    else $error("rotation did not finish");

  occ_stable_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == dqs_pkg::ST_WALK && $past(state) == dqs_pkg::ST_WALK) |->
      $stable(occupancy))
    else $error("occupancy changed mid-rotation");

endmodule

// ===== rtl/dqs_cell.sv =====
// One storage cell of the queue chain: holds an entry, shifts toward either neighbor.
module dqs_cell (
  input  logic                      clk,
  input  dqs_pkg::cell_op_t         op,
  input  logic [dqs_pkg::DATA_W-1:0] from_left,
  input  logic [dqs_pkg::DATA_W-1:0] from_right,
  output logic [dqs_pkg::DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (op)
      dqs_pkg::CELL_SHL: q <= from_right;
      dqs_pkg::CELL_SHR: q <= from_left;
      default:           q <= q;
    endcase
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the double-ended queue with search: directed table plus random phases.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = dqs_pkg::DEPTH;
  localparam int DATA_W      = dqs_pkg::DATA_W;
  localparam int FUNC_W      = dqs_pkg::FUNC_W;
  localparam int POS_W       = dqs_pkg::POS_W;
  localparam int STAT_W      = dqs_pkg::STAT_W;
  localparam int OUT_W       = dqs_pkg::OUT_W;
  localparam int IN_TDATA_W  = dqs_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = dqs_pkg::OUT_TDATA_W;

  // Result fields, removed_value in the lowest bits to match m_tdata
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] removed;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic [DATA_W-1:0] exp_removed;
    logic [POS_W-1:0]  exp_pos;
    logic [STAT_W-1:0] exp_status;
  } dir_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_SEARCH,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = dqs_pkg::FN_SEARCH + 3'd1;
  localparam logic [FUNC_W-1:0] FN_UNUSED_MID   = FN_UNUSED_FIRST + 3'd1;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;
  localparam int DIR_ROWS = 25;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_ERR_PRINTS = 20;

  // Directed rows, starting right after reset. Rows with typed = 0 use the predictor.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{dqs_pkg::FN_REM_FRONT, 32'd0,   1'b1, 32'd0, 7'd0, dqs_pkg::STAT_EMPTY},
    '{dqs_pkg::FN_REM_BACK,  32'd0,   1'b1, 32'd0, 7'd0, dqs_pkg::STAT_EMPTY},
    '{dqs_pkg::FN_SEARCH,    32'd0,   1'b1, 32'd0, 7'd1, dqs_pkg::STAT_NOT_FOUND},
    '{dqs_pkg::FN_SEARCH,    VAL_MIN, 1'b1, 32'd0, 7'd1, dqs_pkg::STAT_NOT_FOUND},
    '{dqs_pkg::FN_INS_FRONT, VAL_MAX, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_INS_BACK,  VAL_MIN, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_INS_FRONT, VAL_NEG1, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_SEARCH,    VAL_MAX, 1'b1, 32'd0, 7'd2, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_SEARCH,    VAL_MIN, 1'b1, 32'd0, 7'd3, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_SEARCH,    32'd0,   1'b1, 32'd0, 7'd4, dqs_pkg::STAT_NOT_FOUND},
    '{FN_UNUSED_FIRST, VAL_NEG1,      1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{FN_UNUSED_MID,   32'hAAAA_AAAA, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{FN_UNUSED_LAST,  32'h5555_5555, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_INS_BACK,  32'd0,   1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_SEARCH,    VAL_NEG1, 1'b1, 32'd0, 7'd1, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_INS_BACK,  VAL_NEG1, 1'b1, 32'd0, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_SEARCH,    VAL_NEG1, 1'b1, 32'd0, 7'd1, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_BACK,  32'd0,   1'b1, VAL_NEG1, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_FRONT, 32'd0,   1'b1, VAL_NEG1, 7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_FRONT, 32'd0,   1'b1, VAL_MAX,  7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_BACK,  32'd0,   1'b1, 32'd0,    7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_BACK,  32'd0,   1'b1, VAL_MIN,  7'd0, dqs_pkg::STAT_OK},
    '{dqs_pkg::FN_REM_FRONT, 32'd0,   1'b1, 32'd0,    7'd0, dqs_pkg::STAT_EMPTY},
    '{dqs_pkg::FN_SEARCH, 32'h1234_5678, 1'b1, 32'd0, 7'd1, dqs_pkg::STAT_NOT_FOUND},
    '{dqs_pkg::FN_INS_BACK, 32'h0000_0001, 1'b0, 32'd0, 7'd0, dqs_pkg::STAT_OK}
  };

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [DATA_W-1:0] deque_contents[$];
  result_t pending_results[$];
  bit no_idle;
  int error_count;
  int items_sent;
  int results_seen;
  int status_count[4];

  double_ended_queue_with_search u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Expected result of one request; updates the deque copy as the block would
  function automatic result_t predict_deque(input logic [FUNC_W-1:0] fn,
                                            input logic [DATA_W-1:0] val);
    result_t r;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (fn)
      dqs_pkg::FN_INS_FRONT, dqs_pkg::FN_INS_BACK: begin
        if (deque_contents.size() >= DEPTH) begin
          r.status = dqs_pkg::STAT_FULL;
        end else if (fn == dqs_pkg::FN_INS_FRONT) begin
          deque_contents.push_front(val);
        end else begin
          deque_contents.push_back(val);
        end
      end
      dqs_pkg::FN_REM_FRONT, dqs_pkg::FN_REM_BACK: begin
        if (deque_contents.size() == 0) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else if (fn == dqs_pkg::FN_REM_FRONT) begin
          r.removed = deque_contents.pop_front();
        end else begin
          r.removed = deque_contents.pop_back();
        end
      end
      dqs_pkg::FN_SEARCH: begin
        for (int i = 0; i < deque_contents.size() && !hit; i++) begin
          if (deque_contents[i] == val) begin
            hit = 1'b1;
            r.pos = POS_W'(i + 1);
          end
        end
        if (!hit) begin
          r.pos = POS_W'(deque_contents.size() + 1);
          r.status = dqs_pkg::STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    int near;
    sel = $urandom_range(0, 99);
    near = $urandom_range(0, 6);
    if (sel < 40) return $urandom;
    if (sel < 65) return DATA_W'(near - 3);
    if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_NEG1;
        default: return '0;
      endcase
    end
    if (deque_contents.size() != 0)
      return deque_contents[$urandom_range(0, deque_contents.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
    int ins_w;
    int rem_w;
    int srch_w;
    int sel;
    case (mix)
      MIX_FILL:   begin ins_w = 70; rem_w = 15; srch_w = 13; end
      MIX_DRAIN:  begin ins_w = 15; rem_w = 70; srch_w = 13; end
      MIX_SEARCH: begin ins_w = 25; rem_w = 25; srch_w = 48; end
      default:    begin ins_w = 32; rem_w = 32; srch_w = 32; end
    endcase
    sel = $urandom_range(0, 99);
    if (sel < ins_w)
      return $urandom_range(0, 1) ? dqs_pkg::FN_INS_BACK : dqs_pkg::FN_INS_FRONT;
    if (sel < ins_w + rem_w)
      return $urandom_range(0, 1) ? dqs_pkg::FN_REM_BACK : dqs_pkg::FN_REM_FRONT;
    if (sel < ins_w + rem_w + srch_w) return dqs_pkg::FN_SEARCH;
    return FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                              input bit typed, input result_t typed_res);
    int gap;
    result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({val, fn});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_deque(fn, val);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Hold off new requests until the block has answered everything or the wait limit runs out
  task automatic drain_pending(input int limit);
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] act_v);
    if (error_count < MAX_ERR_PRINTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[OUT_W-1:0]);
      results_seen++;
      status_count[got.status]++;
      if (pending_results.size() == 0) begin
        if (error_count < MAX_ERR_PRINTS)
          $display("%0t: unexpected transaction, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.removed != want.removed)
          report_mismatch("removed_value", want.removed, got.removed);
        if (got.pos != want.pos) report_mismatch("position", DATA_W'(want.pos), DATA_W'(got.pos));
        if (got.status != want.status)
          report_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
      end
    end
  end

  // Receiver with random backpressure
  initial begin
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t row;
    result_t typed_res;
    mix_t mix;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    no_idle = 1'b0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      typed_res.removed = row.exp_removed;
      typed_res.pos = row.exp_pos;
      typed_res.status = row.exp_status;
      send_request(row.func, row.value, row.typed, typed_res);
    end

    // Random phases: fill toward full, search, drain toward empty, mixed
    for (int p = 0; p < PHASES; p++) begin
      drain_pending(1000);
      mix = mix_t'(p % 4);
      no_idle = (p % 4 == 1) || ($urandom_range(0, 5) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_func(mix), pick_value(), 1'b0, '0);
    end

    drain_pending(20000);
    repeat (DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none", $time,
               pending_results.size());
      error_count += pending_results.size();
    end

    $display("Sent %0d requests across fill, search, drain and mixed phases; %0d results.",
             items_sent, results_seen);
    $display("Status mix: ok %0d, empty %0d, full %0d, not found %0d; %0d errors.",
             status_count[dqs_pkg::STAT_OK], status_count[dqs_pkg::STAT_EMPTY],
             status_count[dqs_pkg::STAT_FULL], status_count[dqs_pkg::STAT_NOT_FOUND],
             error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dqs_pkg.sv
rtl/dqs_cell.sv
rtl/double_ended_queue_with_search.sv
dv/testbench.sv
